[src/aging_neighbor_table_macros.svh]
// Assertion macros shared by the checker of the aging neighbor table.
`ifndef AGING_NEIGHBOR_TABLE_MACROS_SVH
`define AGING_NEIGHBOR_TABLE_MACROS_SVH

// Checked only outside reset.
`define ANBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ANBT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/anbt_pkg.sv]
// Types and constants of the aging neighbor table.
package anbt_pkg;

  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_INSERT = 3'd2;
  localparam logic [2:0] ST_FAR    = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT = 1'd1;

  localparam logic [7:0]  RESET_CUTOFF    = 8'd100;
  localparam logic [15:0] RESET_AGE_LIMIT = 16'd248;
  localparam logic [7:0]  EMPTY_DIST      = 8'd255;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] neighbor_id;
    logic [7:0]  distance;
    logic [31:0] now;
  } anbt_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] neighbor_count;
    logic [7:0] min_distance;
  } anbt_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  distance;
    logic [31:0] stamp;
  } anbt_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MWRITE,
    S_TREAD,
    S_TCHECK,
    S_TMOVE,
    S_OUT
  } anbt_state_t;

endpackage

[src/aging_neighbor_table.sv]
// Aging neighbor table: top level with controller and entry memory.
//
// Request channel (req_valid/req_stall/req): one item per request, kind
// message, tick or clear. The block takes one item at a time; req_stall is
// high from the cycle after acceptance until the controller is back in idle.
// Response channel (rsp_valid/rsp_stall/rsp): exactly one result per item,
// held in an output register, so a new item may be taken while the previous
// result still waits on rsp_stall.
// The controller scans the entry memory, one read per cycle: a searched
// message then updates the match or inserts if there is room; a too-far
// message or unused kind only takes the minimum; clear empties the table;
// a tick walks down, moving the last entry into an expired one's place,
// then scans. The next item can be taken in the cycle after its result is
// loaded. Configuration (cfg_we/cfg_index/cfg_data) is to be written by
// the user while idle only; the block itself does not enforce it.
// Synchronous reset empties the table (count to zero), loads the register
// defaults and drops any pending result; the memory itself is not cleared.
module aging_neighbor_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  anbt_pkg::anbt_in_t                 req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output anbt_pkg::anbt_out_t                rsp,
  input  logic                               cfg_we,
  input  logic [anbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [anbt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import anbt_pkg::*;

  localparam int unsigned CAP = SLOTS - 1;
  localparam int unsigned CW  = $clog2(SLOTS);
  localparam int unsigned AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAP);

  anbt_state_t state, state_next;

  logic [7:0]    cutoff;
  logic [15:0]   age_limit;
  logic [CW-1:0] cnt;
  logic [CW-1:0] ctr;
  anbt_in_t      cur;
  logic          look;
  logic          match;
  logic [AW-1:0] match_idx;
  logic [7:0]    min_acc;
  logic [2:0]    status;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  anbt_entry_t   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  anbt_entry_t   mem_rdata;

  logic          accept;
  logic          rsp_free;
  logic          scan_done;
  logic          expired;
  logic          is_last;
  logic [CW-1:0] ctr_dec;
  logic [CW-1:0] cnt_dec;
  logic [31:0]   age;
  logic [7:0]    cand;
  logic          hit;

  anbt_mem #(.DEPTH(CAP), .AW(AW)) u_anbt_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign accept    = (state == S_IDLE) && req_valid;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign scan_done = (ctr == cnt) && !rd_valid;
  assign ctr_dec   = ctr - 1'b1;
  assign cnt_dec   = cnt - 1'b1;
  assign age       = cur.now - mem_rdata.stamp;
  assign expired   = age > {16'd0, age_limit};
  assign is_last   = (ctr == cnt_dec);
  assign hit       = look && (mem_rdata.id == cur.neighbor_id);
  // a matched entry takes part in the minimum with its new distance
  assign cand      = hit ? cur.distance : mem_rdata.distance;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.kind == KIND_TICK) ? S_TREAD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = look ? S_MWRITE : S_OUT;
        end
      end
      S_MWRITE: state_next = S_OUT;
      S_TREAD: begin
        state_next = (ctr == '0) ? S_SCAN : S_TCHECK;
      end
      S_TCHECK: begin
        state_next = (expired && !is_last) ? S_TMOVE : S_TREAD;
      end
      S_TMOVE: state_next = S_TREAD;
      S_OUT: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != S_IDLE);
    mem_re    = 1'b0;
    mem_raddr = ctr[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = ctr[AW-1:0];
    mem_wdata = mem_rdata;
    unique case (state)
      S_SCAN: begin
        mem_re = (ctr != cnt);
      end
      S_TREAD: begin
        mem_re    = (ctr != '0);
        mem_raddr = ctr_dec[AW-1:0];
      end
      S_TCHECK: begin
        // fetch the last entry to fill the hole
        mem_re    = expired && !is_last;
        mem_raddr = cnt_dec[AW-1:0];
      end
      S_MWRITE: begin
        mem_we             = match || (cnt != CAP_CNT);
        mem_waddr          = match ? match_idx : cnt[AW-1:0];
        mem_wdata.id       = cur.neighbor_id;
        mem_wdata.distance = cur.distance;
        mem_wdata.stamp    = cur.now;
      end
      S_TMOVE: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      cutoff    <= RESET_CUTOFF;
      age_limit <= RESET_AGE_LIMIT;
    end else begin
      state    <= state_next;
      rd_valid <= (state == S_SCAN) && (ctr != cnt);

      if (cfg_we) begin
        unique case (cfg_index)
          REG_CUTOFF:    cutoff    <= cfg_data[7:0];
          REG_AGE_LIMIT: age_limit <= cfg_data;
          default: begin
          end
        endcase
      end

      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_MWRITE: begin
          if (!match && (cnt != CAP_CNT)) begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TCHECK: begin
          if (expired && is_last) begin
            cnt <= cnt_dec;
          end
        end
        S_TMOVE: begin
          cnt <= cnt_dec;
        end
        S_OUT: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          if (accept && (req.kind == KIND_CLEAR)) begin
            cnt <= '0;
          end
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= ctr[AW-1:0];
    if (accept) begin
      cur     <= req;
      ctr     <= '0;
      min_acc <= EMPTY_DIST;
      match   <= 1'b0;
      look    <= 1'b0;
      status  <= ST_NONE;
      if (req.kind == KIND_MSG) begin
        if (req.distance > cutoff) begin
          status <= ST_FAR;
        end else begin
          look <= 1'b1;
        end
      end
      if (req.kind == KIND_TICK) begin
        ctr <= cnt;
      end
    end
    if ((state == S_SCAN) && (ctr != cnt)) begin
      ctr <= ctr + 1'b1;
    end
    if ((state == S_TREAD) && (ctr != '0)) begin
      ctr <= ctr_dec;
    end
    if ((state == S_SCAN) && rd_valid) begin
      if (cand < min_acc) begin
        min_acc <= cand;
      end
      if (hit) begin
        match     <= 1'b1;
        match_idx <= rd_idx;
      end
    end
    if (state == S_MWRITE) begin
      if (match) begin
        status <= ST_UPDATE;
      end else if (cnt == CAP_CNT) begin
        status <= ST_FULL;
      end else begin
        status <= ST_INSERT;
      end
    end
    if ((state == S_MWRITE) && !match && (cnt != CAP_CNT) && (cur.distance < min_acc)) begin
      min_acc <= cur.distance;
    end
    if ((state == S_OUT) && rsp_free) begin
      rsp.status         <= status;
      rsp.neighbor_count <= 4'(cnt);
      rsp.min_distance   <= min_acc;
    end
  end

endmodule

[src/anbt_mem.sv]
// Entry memory: one write port, one read port with registered data.
module anbt_mem #(
  parameter int unsigned DEPTH = 15,
  parameter int unsigned AW    = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  anbt_pkg::anbt_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output anbt_pkg::anbt_entry_t rd_data
);
  import anbt_pkg::*;

  anbt_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/anbt_checker.sv]
// Port-level checker for the aging neighbor table, with its bind.
`include "aging_neighbor_table_macros.svh"

module anbt_checker #(
  parameter int unsigned SLOTS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input anbt_pkg::anbt_out_t rsp
);
  import anbt_pkg::*;

  localparam logic [3:0] FULL_COUNT = 4'(SLOTS - 1);

  `ANBT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result changed")
  `ANBT_ASSERT(a_one_item, req_valid && !req_stall |=> req_stall, "second item taken while busy")
  `ANBT_ASSERT_ALWAYS(a_reset_idle, rst |=> !rsp_valid && !req_stall, "not idle after reset")
  `ANBT_ASSERT(a_full_count, rsp_valid && rsp.status == ST_FULL |-> rsp.neighbor_count == FULL_COUNT, "drop reported below capacity")

endmodule

bind aging_neighbor_table anbt_checker #(.SLOTS(SLOTS)) u_anbt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

[test/tb_aging_neighbor_table.sv]
// Self-checking testbench of the aging neighbor table: directed table, then random phases.
module tb_aging_neighbor_table;
  timeunit 1ns;
  timeprecision 1ps;

  import anbt_pkg::*;

  localparam int unsigned TB_SLOTS = 16;
  localparam int unsigned CAPACITY = TB_SLOTS - 1;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    anbt_in_t  item;
    bit        typed;
    anbt_out_t report;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  anbt_in_t              req;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  anbt_out_t             rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the table and its registers
  logic [15:0]  nb_id [CAPACITY];
  logic [7:0]   nb_dist [CAPACITY];
  logic [31:0]  nb_stamp [CAPACITY];
  int unsigned  nb_count;
  logic [7:0]   cutoff_shadow;
  logic [15:0]  age_shadow;

  anbt_out_t    reports_q[$];
  anbt_out_t    want_report;
  dir_row_t     dir_rows[$];
  logic [15:0]  id_pool[$];
  logic [31:0]  tick_now;
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  stall_left = 0;
  bit           idle_on = 1'b1;

  aging_neighbor_table #(.SLOTS(TB_SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic anbt_out_t apply_to_table(anbt_in_t it);
    anbt_out_t   r;
    int unsigned k;
    int unsigned last;
    logic [31:0] age;
    bit          hit;
    r.status = ST_NONE;
    hit = 1'b0;
    case (it.kind)
      KIND_MSG: begin
        if (it.distance > cutoff_shadow) begin
          r.status = ST_FAR;
        end else begin
          for (k = 0; k < nb_count; k++) begin
            if (!hit && nb_id[k] == it.neighbor_id) begin
              nb_dist[k] = it.distance;
              nb_stamp[k] = it.now;
              hit = 1'b1;
              r.status = ST_UPDATE;
            end
          end
          if (!hit) begin
            if (nb_count >= CAPACITY) begin
              r.status = ST_FULL;
            end else begin
              nb_id[nb_count] = it.neighbor_id;
              nb_dist[nb_count] = it.distance;
              nb_stamp[nb_count] = it.now;
              nb_count++;
              r.status = ST_INSERT;
            end
          end
        end
      end
      KIND_TICK: begin
        // walk down; an expired entry takes the current last one
        k = nb_count;
        while (k > 0) begin
          k--;
          age = it.now - nb_stamp[k];
          if (age > {16'd0, age_shadow}) begin
            last = nb_count - 1;
            nb_id[k] = nb_id[last];
            nb_dist[k] = nb_dist[last];
            nb_stamp[k] = nb_stamp[last];
            nb_count = last;
          end
        end
      end
      KIND_CLEAR: nb_count = 0;
      default: ;
    endcase
    r.neighbor_count = 4'(nb_count);
    r.min_distance = EMPTY_DIST;
    for (k = 0; k < nb_count; k++) begin
      if (nb_dist[k] < r.min_distance) r.min_distance = nb_dist[k];
    end
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [15:0] id,
                                  input logic [7:0] dst, input logic [31:0] now,
                                  input bit typed = 1'b0, input logic [2:0] st = ST_NONE,
                                  input logic [3:0] cnt = 4'd0, input logic [7:0] mind = 8'd0);
    dir_row_t r;
    r.item.kind = kind;
    r.item.neighbor_id = id;
    r.item.distance = dst;
    r.item.now = now;
    r.typed = typed;
    r.report.status = st;
    r.report.neighbor_count = cnt;
    r.report.min_distance = mind;
    dir_rows.push_back(r);
  endfunction

  function automatic anbt_in_t make_item();
    anbt_in_t    it;
    int unsigned roll;
    int unsigned step_max;
    step_max = age_shadow / 4 + 3;
    roll = $urandom_range(0, 99);
    it.kind = KIND_MSG;
    it.neighbor_id = id_pool[$urandom_range(0, id_pool.size() - 1)];
    if ($urandom_range(0, 9) == 0)
      it.distance = cutoff_shadow;
    else if ($urandom_range(0, 7) == 0)
      it.distance = 8'($urandom_range(0, 255));
    else
      it.distance = 8'($urandom_range(0, cutoff_shadow));
    it.now = tick_now;
    if (roll < 62) begin
      tick_now += $urandom_range(0, step_max);
    end else if (roll < 80) begin
      it.kind = KIND_TICK;
      tick_now += $urandom_range(0, step_max);
    end else if (roll < 82) begin
      it.kind = KIND_CLEAR;
    end else if (roll < 86) begin
      it.kind = KIND_UNUSED;
    end else begin
      it.kind = 2'($urandom_range(0, 3));
      it.neighbor_id = 16'($urandom);
      it.distance = 8'($urandom);
      it.now = $urandom;
    end
    return it;
  endfunction

  task automatic send_item(input anbt_in_t it, input bit typed, input anbt_out_t typed_report);
    anbt_out_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = apply_to_table(it);
    reports_q.push_back(typed ? typed_report : predicted);
    @(negedge clk);
  endtask

  task automatic drain_table();
    req_valid <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CUTOFF)
      cutoff_shadow = val[7:0];
    else
      age_shadow = val;
    @(negedge clk);
  endtask

  // result stalls in bursts
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (reports_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, rsp);
        errors++;
      end else begin
        want_report = reports_q.pop_front();
        if (rsp.status !== want_report.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want_report.status,
                   rsp.status);
          errors++;
        end
        if (rsp.neighbor_count !== want_report.neighbor_count) begin
          $display("%0t: neighbor_count expected %0d actual %0d", $time,
                   want_report.neighbor_count, rsp.neighbor_count);
          errors++;
        end
        if (rsp.min_distance !== want_report.min_distance) begin
          $display("%0t: min_distance expected %0d actual %0d", $time,
                   want_report.min_distance, rsp.min_distance);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned n;
    int          k;
    anbt_in_t    it;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CUTOFF;
    cfg_data = '0;
    cutoff_shadow = RESET_CUTOFF;
    age_shadow = RESET_AGE_LIMIT;
    nb_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows under the reset register values
    add_row(KIND_TICK, 16'h0000, 8'd0, 32'd0, 1'b1, ST_NONE, 4'd0, EMPTY_DIST);
    add_row(KIND_CLEAR, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_NONE, 4'd0, EMPTY_DIST);
    add_row(KIND_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_NONE, 4'd0, EMPTY_DIST);
    add_row(KIND_MSG, 16'h0000, 8'd101, 32'd0, 1'b1, ST_FAR, 4'd0, EMPTY_DIST);
    add_row(KIND_MSG, 16'h0000, 8'd100, 32'd0, 1'b1, ST_INSERT, 4'd1, 8'd100);
    add_row(KIND_MSG, 16'hFFFF, 8'd0, 32'hFFFF_FFFF, 1'b1, ST_INSERT, 4'd2, 8'd0);
    add_row(KIND_MSG, 16'h0000, 8'd50, 32'd10);
    add_row(KIND_UNUSED, 16'h0000, 8'd0, 32'd0);
    for (k = 1; k <= 13; k++) add_row(KIND_MSG, 16'(k * 'h1111), 8'(k * 7 + 8), 32'(100 + k));
    add_row(KIND_MSG, 16'h1234, 8'd1, 32'd200, 1'b1, ST_FULL, 4'd15, 8'd0);
    // stamp wrapped from the top of the range expires, limit-aged entry stays
    add_row(KIND_TICK, 16'h0000, 8'd0, 32'd258);
    add_row(KIND_MSG, 16'h1234, 8'd1, 32'd300);
    add_row(KIND_TICK, 16'h0000, 8'd0, 32'h8000_0000, 1'b1, ST_NONE, 4'd0, EMPTY_DIST);
    add_row(KIND_CLEAR, 16'h0000, 8'd0, 32'd0, 1'b1, ST_NONE, 4'd0, EMPTY_DIST);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].report);

    for (p = 0; p < RAND_PHASES; p++) begin
      drain_table();
      tick_now = $urandom;
      case (p)
        0: begin
          write_reg(REG_CUTOFF, 16'd255);
          write_reg(REG_AGE_LIMIT, 16'd0);
        end
        1: begin
          write_reg(REG_CUTOFF, 16'd0);
          write_reg(REG_AGE_LIMIT, 16'hFFFF);
        end
        2: begin
          write_reg(REG_CUTOFF, 16'd255);
          write_reg(REG_AGE_LIMIT, 16'hFFFF);
          tick_now = 32'hFFFF_F000;
        end
        3: begin
          write_reg(REG_CUTOFF, 16'($urandom_range(0, 255)));
          write_reg(REG_AGE_LIMIT, 16'($urandom_range(0, 600)));
        end
        4: begin
          write_reg(REG_CUTOFF, 16'd180);
          write_reg(REG_AGE_LIMIT, 16'd40);
          tick_now = 32'hFFFF_FFC0;
        end
        default: begin
          write_reg(REG_CUTOFF, 16'(RESET_CUTOFF));
          write_reg(REG_AGE_LIMIT, RESET_AGE_LIMIT);
        end
      endcase
      id_pool.delete();
      n = $urandom_range(16, 24);
      repeat (n) id_pool.push_back(16'($urandom));
      idle_on = !(p == 3 || p == RAND_PHASES - 1);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        it = make_item();
        if (it.kind != KIND_UNUSED) n++;
        send_item(it, 1'b0, '0);
      end
    end

    req_valid <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/anbt_pkg.sv
src/anbt_mem.sv
src/aging_neighbor_table.sv
src/anbt_checker.sv
test/tb_aging_neighbor_table.sv
